// ----- rtl/bss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_pkg: shared types and constants of the bounded set store
// item layouts, command codes, sequencer states and default sizes
// ----------------------------------------------------------------------------
package bss_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 5;
    localparam int CMD_W        = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MEMBER = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SUBSET = 3'd3;
    localparam logic [CMD_W-1:0] CMD_UNION  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_INTER  = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic                      set_sel;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic                      status;
        logic                      truth;
        logic signed [VALUE_W-1:0] element;
        logic                      element_valid;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEXT,
        ST_FETCH,
        ST_FETCH_W,
        ST_SCAN,
        ST_LIST,
        ST_FINISH
    } state_t;

endpackage

// ----- rtl/bounded_set_store_ops.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_set_store_ops: two bounded value sets with set-algebra commands
// clear, append, member test, subset test, union and intersection listing
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the command is done. Results come out on result, one per cycle at
// most, each marked by a one-cycle result_valid pulse, and must be taken as
// they come: there is no back pressure. The final result of a command has
// last set. All work runs through one ram read port per set (both fed from
// one address) and one 32-bit equality comparator, walked by a small
// sequencer, so latency follows the number of stored entries compared.
// Clear, append and undefined commands need no scan; a member test scans
// the selected set; subset and intersection scan B for each entry of A;
// union lists A, then scans A and the earlier B entries for each B entry,
// cut short once the list is full. A new item can be taken in the cycle
// the last result shows.
// ----------------------------------------------------------------------------
module bounded_set_store_ops
    import bss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  request,
    output logic      result_valid,
    output out_item_t result
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    // sequencer control
    state_t            state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic              sel_reg, sel_next;
    logic [CW-1:0]     cnt_a_reg, cnt_a_next;
    logic [CW-1:0]     cnt_b_reg, cnt_b_next;
    logic [CW-1:0]     outer_reg, outer_next;   // outer loop position
    logic [CW-1:0]     idx_reg, idx_next;       // scan read position
    logic [CW-1:0]     lim_reg, lim_next;       // scan length
    logic [CW-1:0]     n_reg, n_next;           // listed elements so far
    logic              pend_reg, pend_next;     // scan read in flight
    logic              scan_b_reg, scan_b_next; // scan walks set b
    logic              ph_reg, ph_next;         // union: walking b entries
    logic              step_reg, step_next;     // union: second scan over b
    logic              truth_reg, truth_next;
    logic              hold_v_reg, hold_v_next;
    logic              res_valid_reg, res_valid_next;

    // payload
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [VALUE_W-1:0] key_reg, key_next;
    logic [VALUE_W-1:0] hold_reg, hold_next;    // element waiting to go out
    out_item_t          res_reg, res_next;

    // ram side
    logic               we_a, we_b;
    logic [IW-1:0]      waddr;
    logic [IW-1:0]      raddr;
    logic [VALUE_W-1:0] rdata_a, rdata_b;
    logic [VALUE_W-1:0] scan_rdata;
    logic               scan_hit, scan_miss;
    logic [CW-1:0]      cnt_sel;

    bss_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram_a (
        .clk  (clk),
        .we   (we_a),
        .waddr(waddr),
        .wdata(value_reg),
        .raddr(raddr),
        .rdata(rdata_a)
    );

    bss_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram_b (
        .clk  (clk),
        .we   (we_b),
        .waddr(waddr),
        .wdata(value_reg),
        .raddr(raddr),
        .rdata(rdata_b)
    );

    // the one shared comparator
    assign scan_rdata = scan_b_reg ? rdata_b : rdata_a;
    assign scan_hit   = pend_reg && (scan_rdata == key_reg);
    assign scan_miss  = !scan_hit && !(idx_reg < lim_reg);

    assign cnt_sel = sel_reg ? cnt_b_reg : cnt_a_reg;
    assign waddr   = cnt_sel[IW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        sel_next       = sel_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        outer_next     = outer_reg;
        idx_next       = idx_reg;
        lim_next       = lim_reg;
        n_next         = n_reg;
        pend_next      = pend_reg;
        scan_b_next    = scan_b_reg;
        ph_next        = ph_reg;
        step_next      = step_reg;
        truth_next     = truth_reg;
        hold_v_next    = hold_v_reg;
        value_next     = value_reg;
        key_next       = key_reg;
        hold_next      = hold_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        we_a           = 1'b0;
        we_b           = 1'b0;
        raddr          = idx_reg[IW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = request.cmd;
                    sel_next    = request.set_sel;
                    value_next  = request.value;
                    outer_next  = '0;
                    n_next      = '0;
                    ph_next     = 1'b0;
                    step_next   = 1'b0;
                    hold_v_next = 1'b0;
                    truth_next  = 1'b1;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    case (request.cmd)
                        CMD_MEMBER:
                        begin
                            scan_b_next = request.set_sel;
                            lim_next    = request.set_sel ? cnt_b_reg : cnt_a_reg;
                            key_next    = request.value;
                            state_next  = ST_SCAN;
                        end
                        CMD_SUBSET, CMD_UNION, CMD_INTER:
                        begin
                            state_next = ST_NEXT;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_NEXT:
            begin
                case (cmd_reg)
                    CMD_SUBSET, CMD_INTER:
                    begin
                        state_next = (outer_reg == cnt_a_reg) ? ST_FINISH : ST_FETCH;
                    end
                    CMD_UNION:
                    begin
                        if (!ph_reg)
                        begin
                            if (outer_reg == cnt_a_reg)
                            begin
                                ph_next    = 1'b1;
                                outer_next = '0;
                            end
                            else
                            begin
                                state_next = ST_FETCH;
                            end
                        end
                        else if (outer_reg == cnt_b_reg || n_reg == CAP_C)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_FETCH;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_FETCH:
            begin
                raddr      = outer_reg[IW-1:0];
                state_next = ST_FETCH_W;
            end

            ST_FETCH_W:
            begin
                key_next  = ph_reg ? rdata_b : rdata_a;
                idx_next  = '0;
                pend_next = 1'b0;
                step_next = 1'b0;
                if (cmd_reg == CMD_UNION)
                begin
                    if (ph_reg)
                    begin
                        // first look for the b entry among all of a
                        scan_b_next = 1'b0;
                        lim_next    = cnt_a_reg;
                        state_next  = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_LIST;
                    end
                end
                else
                begin
                    scan_b_next = 1'b1;
                    lim_next    = cnt_b_reg;
                    state_next  = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (scan_hit || scan_miss)
                begin
                    pend_next = 1'b0;
                    case (cmd_reg)
                        CMD_MEMBER:
                        begin
                            truth_next = scan_hit;
                            state_next = ST_FINISH;
                        end
                        CMD_SUBSET:
                        begin
                            if (scan_hit)
                            begin
                                outer_next = outer_reg + ONE_C;
                                state_next = ST_NEXT;
                            end
                            else
                            begin
                                truth_next = 1'b0;
                                state_next = ST_FINISH;
                            end
                        end
                        CMD_INTER:
                        begin
                            if (scan_hit)
                            begin
                                state_next = ST_LIST;
                            end
                            else
                            begin
                                outer_next = outer_reg + ONE_C;
                                state_next = ST_NEXT;
                            end
                        end
                        CMD_UNION:
                        begin
                            if (scan_hit)
                            begin
                                outer_next = outer_reg + ONE_C;
                                state_next = ST_NEXT;
                            end
                            else if (!step_reg)
                            begin
                                // then among the earlier b entries
                                step_next   = 1'b1;
                                scan_b_next = 1'b1;
                                lim_next    = outer_reg;
                                idx_next    = '0;
                            end
                            else
                            begin
                                state_next = ST_LIST;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
                else if (idx_reg < lim_reg)
                begin
                    idx_next  = idx_reg + ONE_C;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            ST_LIST:
            begin
                // an element goes out once the next one is known, so the
                // final one can carry last
                if (hold_v_reg)
                begin
                    res_next.status        = 1'b0;
                    res_next.truth         = 1'b0;
                    res_next.element       = hold_reg;
                    res_next.element_valid = 1'b1;
                    res_next.count         = COUNT_W'(cnt_a_reg);
                    res_next.last          = 1'b0;
                    res_valid_next         = 1'b1;
                end
                hold_next   = key_reg;
                hold_v_next = 1'b1;
                n_next      = n_reg + ONE_C;
                outer_next  = outer_reg + ONE_C;
                state_next  = ST_NEXT;
            end

            ST_FINISH:
            begin
                res_next.status        = 1'b0;
                res_next.truth         = 1'b0;
                res_next.element       = '0;
                res_next.element_valid = 1'b0;
                res_next.count         = COUNT_W'(cnt_a_reg);
                res_next.last          = 1'b1;
                res_valid_next         = 1'b1;
                state_next             = ST_IDLE;
                case (cmd_reg)
                    CMD_CLEAR:
                    begin
                        if (sel_reg)
                        begin
                            cnt_b_next = '0;
                        end
                        else
                        begin
                            cnt_a_next = '0;
                        end
                        res_next.count = '0;
                    end
                    CMD_APPEND:
                    begin
                        if (cnt_sel >= CAP_C)
                        begin
                            res_next.status = 1'b1;
                            res_next.count  = COUNT_W'(cnt_sel);
                        end
                        else
                        begin
                            we_a           = !sel_reg;
                            we_b           = sel_reg;
                            res_next.count = COUNT_W'(cnt_sel + ONE_C);
                            if (sel_reg)
                            begin
                                cnt_b_next = cnt_b_reg + ONE_C;
                            end
                            else
                            begin
                                cnt_a_next = cnt_a_reg + ONE_C;
                            end
                        end
                    end
                    CMD_MEMBER:
                    begin
                        res_next.truth = truth_reg;
                        res_next.count = COUNT_W'(cnt_sel);
                    end
                    CMD_SUBSET:
                    begin
                        res_next.truth = truth_reg;
                    end
                    CMD_UNION, CMD_INTER:
                    begin
                        // empty list gives one result with no element
                        if (hold_v_reg)
                        begin
                            res_next.element       = hold_reg;
                            res_next.element_valid = 1'b1;
                        end
                    end
                    default:
                    begin
                        res_next.count = COUNT_W'(cnt_a_reg);
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= CMD_CLEAR;
            sel_reg       <= 1'b0;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            outer_reg     <= '0;
            idx_reg       <= '0;
            lim_reg       <= '0;
            n_reg         <= '0;
            pend_reg      <= 1'b0;
            scan_b_reg    <= 1'b0;
            ph_reg        <= 1'b0;
            step_reg      <= 1'b0;
            truth_reg     <= 1'b0;
            hold_v_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            sel_reg       <= sel_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            outer_reg     <= outer_next;
            idx_reg       <= idx_next;
            lim_reg       <= lim_next;
            n_reg         <= n_next;
            pend_reg      <= pend_next;
            scan_b_reg    <= scan_b_next;
            ph_reg        <= ph_next;
            step_reg      <= step_next;
            truth_reg     <= truth_next;
            hold_v_reg    <= hold_v_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        key_reg   <= key_next;
        hold_reg  <= hold_next;
        res_reg   <= res_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef SYNTH
    // set counts never pass capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a_reg <= CAP_C) && (cnt_b_reg <= CAP_C))
        else $error("set count above capacity");

    // list length never passes capacity
    a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CAP_C)
        else $error("list longer than capacity");

    // every command ends with exactly one closing result
    a_finish_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |=> (result_valid && result.last))
        else $error("finish without closing result");

    // a non-final result only appears while the command is still running
    a_open_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> busy)
        else $error("non-final result after command end");

    // a dropped append reports a full set
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status) |-> (result.count == COUNT_W'(CAPACITY)))
        else $error("dropped append on a set that is not full");
`endif

endmodule

// ----- rtl/bss_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_ram: generic single-write, single-read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
